>>> design/shtd_pkg.sv
package shtd_pkg;

   // Width of one per-station hit identifier
   localparam int HIT_W = 16;

   // Width of the shared-hit threshold register
   localparam int THR_W = 3;

   // Threshold value after reset
   localparam logic [THR_W-1:0] THR_RESET = 3'd2;

   // Number of station fields carried on the request channel
   localparam int IN_STATIONS = 4;

   // Request kinds carried on req_tuser
   localparam logic ACT_CLEAR = 1'b0;
   localparam logic ACT_OFFER = 1'b1;

   // Per-cycle commands broadcast to every cell of the chain
   typedef struct packed {
      logic load;   // latch this cell's match bit into its flag
      logic shift;  // take the flag of the neighbour above
      logic wr;     // store the candidate if this cell is the next free slot
   } shtd_ctrl_type;

endpackage

>>> design/shtd_cell.sv
module shtd_cell #(
   parameter int INDEX    = 0,
   parameter int CNT_W    = 9,
   parameter int STATIONS = 4
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  shtd_pkg::shtd_ctrl_type                 ctrl,
   input  logic [STATIONS-1:0][shtd_pkg::HIT_W-1:0] cand,
   input  logic [shtd_pkg::THR_W-1:0]              min_shared,
   input  logic [CNT_W-1:0]                        committed,
   input  logic [CNT_W-1:0]                        total,
   input  logic                                    flag_up,
   output logic                                    flag
);
   import shtd_pkg::*;

   localparam int SUM_W = $clog2(STATIONS + 1);
   localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

   logic [STATIONS-1:0][HIT_W-1:0] track_ff;
   logic                           flag_ff;
   logic                           flag_in;
   logic [SUM_W-1:0]               same;
   logic                           visible;
   logic                           selected;
   logic                           match;

   // Count stations with equal nonzero identifiers
   always_comb begin
      same = '0;
      for (int s = 0; s < STATIONS; s++) begin
         if ((track_ff[s] != '0) && (track_ff[s] == cand[s])) begin
            same = same + SUM_W'(1);
         end
      end
   end

   // Only tracks committed before the running range take part
   assign visible  = (CNT_W'(INDEX) < committed);
   assign selected = (CNT_W'(INDEX) == total);
   assign match    = visible && (CMP_W'(same) >= CMP_W'(min_shared));

   // Load the match bit, or pass the flag down towards cell zero
   always_comb begin
      flag_in = flag_ff;
      if (ctrl.load) begin
         flag_in = match;
      end else if (ctrl.shift) begin
         flag_in = flag_up;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else begin
         flag_ff <= flag_in;
      end
   end

   // Store the candidate when this cell is the next free slot
   always_ff @(posedge clock) begin
      if (ctrl.wr && selected) begin
         track_ff <= cand;
      end
   end

   assign flag = flag_ff;

endmodule

>>> design/shared_hit_track_dedup_core.sv
// Duplicate-track filter for one event.
// req_*: one transfer per request. req_tuser is the action (clear or offer a
// candidate), req_tdata holds four 16-bit hit identifiers, req_tlast marks the
// last candidate of a search range, after which all stored tracks are committed.
// rsp_*: one transfer per request, carrying the slot index and the accepted
// and table-full flags. csr_*: writes the shared-hit threshold; the port is always
// ready. Write it only while the block is idle; the block does not enforce this.
// Each stored track sits in one cell of a chain. On a candidate every cell
// compares its track in parallel, then the match flags shift one
// cell per cycle towards cell zero, where they are collected; the scan stops
// at the first match or after committed_count shifts.
// One request is in work at a time. A clear goes from its transfer straight to
// the finish step; an offer passes through the compare, scan and finish steps.
// The next request is taken as soon as the previous response is registered,
// even while that response still waits on rsp_tready; a stalled receiver holds
// the response and then the following result in its finish step.
// Reset empties the table (both counts zero) and sets the threshold to 2.
module shared_hit_track_dedup_core #(
   parameter int TABLE_DEPTH = 256,
   parameter int STATIONS    = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [63:0]                    req_tdata,  // hit_id_station0..3, 16 bits each
   input  logic                           req_tuser,  // action
   input  logic                           req_tlast,  // end_of_range
   // Response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,  // slot_index
   output logic [1:0]                     rsp_tuser,  // accepted, table_full
   // Threshold write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [shtd_pkg::THR_W-1:0]     csr_data
);
   import shtd_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_COMPARE = 2'd1;
   localparam logic [1:0] ST_SCAN    = 2'd2;
   localparam logic [1:0] ST_FINISH  = 2'd3;

   logic [1:0]                     state_ff, state_in;
   logic [THR_W-1:0]               min_shared_ff, min_shared_in;
   logic [CNT_W-1:0]               committed_ff, committed_in;
   logic [CNT_W-1:0]               total_ff, total_in;
   logic [CNT_W-1:0]               scan_ff, scan_in;
   logic                           dup_ff, dup_in;
   logic                           action_ff;
   logic                           eor_ff;
   logic [STATIONS-1:0][HIT_W-1:0] cand_ff;
   logic [STATIONS-1:0][HIT_W-1:0] cand_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [7:0]                     rsp_slot_ff, rsp_slot_in;
   logic                           rsp_acc_ff, rsp_acc_in;
   logic                           rsp_full_ff, rsp_full_in;
   logic [CNT_W+7:0]               slot_wide;
   logic                           req_xfer;
   logic                           out_free;
   logic                           finishing;
   logic                           room;
   logic                           cand_new;
   shtd_ctrl_type                  ctrl;
   logic [TABLE_DEPTH:0]           flag_chain;

   assign req_xfer  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign finishing = (state_ff == ST_FINISH) && out_free;
   assign room      = (total_ff < CNT_W'(TABLE_DEPTH));
   assign cand_new  = (action_ff == ACT_OFFER) && !dup_ff;
   assign slot_wide = {8'd0, total_ff};

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   // Unpack the candidate; stations past the request fields hold zero
   always_comb begin
      for (int s = 0; s < STATIONS; s++) begin
         if (s < IN_STATIONS) begin
            cand_in[s] = req_tdata[(s % IN_STATIONS) * HIT_W +: HIT_W];
         end else begin
            cand_in[s] = '0;
         end
      end
   end

   // Commands for the cell chain
   always_comb begin
      ctrl.load  = (state_ff == ST_COMPARE);
      ctrl.shift = (state_ff == ST_SCAN);
      ctrl.wr    = finishing && cand_new;
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      min_shared_in = min_shared_ff;
      committed_in  = committed_ff;
      total_in      = total_ff;
      scan_in       = scan_ff;
      dup_in        = dup_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_full_in   = rsp_full_ff;

      if (csr_valid && csr_ready) begin
         min_shared_in = csr_data;
      end

      // Drop the response once it is taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               dup_in  = 1'b0;
               scan_in = '0;
               if (req_tuser == ACT_OFFER) begin
                  state_in = ST_COMPARE;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_COMPARE: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // Cell zero holds the match bit of slot scan_ff
            if (scan_ff == committed_ff) begin
               state_in = ST_FINISH;
            end else if (flag_chain[0]) begin
               dup_in   = 1'b1;
               state_in = ST_FINISH;
            end else begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_acc_in   = 1'b0;
               rsp_slot_in  = '0;
               rsp_full_in  = 1'b0;
               if (action_ff == ACT_CLEAR) begin
                  committed_in = '0;
                  total_in     = '0;
               end else begin
                  if (cand_new) begin
                     if (room) begin
                        rsp_acc_in  = 1'b1;
                        rsp_slot_in = slot_wide[7:0];
                        total_in    = total_ff + CNT_W'(1);
                     end else begin
                        rsp_full_in = 1'b1;
                     end
                  end
                  if (eor_ff) begin
                     committed_in = total_in;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         min_shared_ff <= THR_RESET;
         committed_ff  <= '0;
         total_ff      <= '0;
         scan_ff       <= '0;
         dup_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         min_shared_ff <= min_shared_in;
         committed_ff  <= committed_in;
         total_ff      <= total_in;
         scan_ff       <= scan_in;
         dup_ff        <= dup_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         action_ff <= req_tuser;
         eor_ff    <= req_tlast;
         cand_ff   <= cand_in;
      end
      rsp_slot_ff <= rsp_slot_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_full_ff <= rsp_full_in;
   end

   // Chain of track cells; flags move towards cell zero
   assign flag_chain[TABLE_DEPTH] = 1'b0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      shtd_cell #(
         .INDEX    (i),
         .CNT_W    (CNT_W),
         .STATIONS (STATIONS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .cand       (cand_ff),
         .min_shared (min_shared_ff),
         .committed  (committed_ff),
         .total      (total_ff),
         .flag_up    (flag_chain[i+1]),
         .flag       (flag_chain[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_slot_ff;
   assign rsp_tuser  = {rsp_full_ff, rsp_acc_ff};

endmodule
